/* rtl/ssp_pkg.sv */
// Shared types, constants and arithmetic helpers of the spiral marker generator.
`default_nettype none

package ssp_pkg;

    localparam int CNT_W = 7;
    localparam int IDX_W = 6;

    localparam int CORDIC_STEPS = 30;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [31:0] PI_Q29      = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314856;
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [31:0] STEP_C      = 32'd1932735283;
    localparam logic [31:0] RECIP5      = 32'hCCCCCCCD;

    // State of one digit-by-digit square root.
    typedef struct packed {
        logic [61:0] rad;
        logic [33:0] rem;
        logic [30:0] root;
    } t_sqrt;

    // Everything one marker carries down the pipeline.
    typedef struct packed {
        logic        valid;
        logic [6:0]  cnt;
        logic [5:0]  nm1;
        logic [5:0]  idx;
        logic        first;
        logic        last;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] radius;
        logic [30:0] id;
        logic [15:0] cpu;
        logic [28:0] rad_q;
        logic [30:0] r;
        logic        ck_neg;
        logic [6:0]  ck_rem;
        logic [30:0] ck_mag;
        t_sqrt       sq_q;
        t_sqrt       sq_s;
        logic [31:0] dv_rem;
        logic [31:0] dv_lo;
        logic [31:0] dv_quo;
        logic [31:0] dv_div;
        logic [31:0] rs;
        logic [31:0] az;
        logic        flip;
        logic [33:0] cor_x;
        logic [33:0] cor_y;
        logic [33:0] cor_z;
        logic [66:0] px_p;
        logic [66:0] py_p;
        logic [63:0] pz_p;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
    } t_stage;

    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // One radix-4 step of an exact floor square root.
    function automatic t_sqrt sqrt_step(input t_sqrt a);
        t_sqrt       b;
        logic [33:0] rem2;
        logic [33:0] trial;
        rem2  = {a.rem[31:0], a.rad[61:60]};
        trial = {1'b0, a.root, 2'b01};
        b.rad = {a.rad[59:0], 2'b00};
        if (rem2 >= trial) begin
            b.rem  = rem2 - trial;
            b.root = {a.root[29:0], 1'b1};
        end else begin
            b.rem  = rem2;
            b.root = {a.root[29:0], 1'b0};
        end
        return b;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] o;
        if (v > 40'sd2147483647) begin
            o = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            o = 32'h8000_0000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/ssp_marker_pipe.sv */
// Per-marker datapath: divider, square roots, azimuth, CORDIC and placement stages.
`default_nettype none

module ssp_marker_pipe
    import ssp_pkg::*;
#(
    parameter int DIMENSIONS = 3
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_adv,
    input  wire t_stage  i_issue,
    output t_stage       o_tail
);

    localparam int ST_LOAD = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_SQ   = 33;
    localparam int ST_SQS0 = 34;
    localparam int ST_RS   = 65;
    localparam int ST_AZ   = 66;
    localparam int ST_FOLD = 67;
    localparam int ST_COR0 = 68;
    localparam int ST_MUL  = 98;
    localparam int DEPTH   = 99;

    t_stage      r_pipe [1:DEPTH];
    t_stage      n_pipe [1:DEPTH];
    t_stage      w_prev [1:DEPTH];
    logic [31:0] r_az_acc;

    assign w_prev[1] = i_issue;

    genvar k;
    generate
        for (k = 1; k <= DEPTH; k++) begin : g_stage
            if (k > 1) begin : g_link
                assign w_prev[k] = r_pipe[k-1];
            end

            always_comb begin
                t_stage             p;
                t_stage             q;
                logic signed [7:0]  num;
                logic [5:0]         mag;
                logic [18:0]        m;
                logic [62:0]        rq_prod;
                logic [37:0]        sp_prod;
                logic [2:0]         rem5;
                logic [1:0]         frac;
                logic [6:0]         t;
                logic [61:0]        cksq;
                logic [31:0]        rem2;
                logic [61:0]        rs_prod;
                logic [32:0]        azs;
                logic signed [33:0] fz;
                logic signed [33:0] x;
                logic signed [33:0] y;
                logic signed [33:0] z;
                logic signed [33:0] at;
                logic signed [31:0] ck_s;
                logic signed [39:0] sx;
                logic signed [39:0] sy;
                logic signed [39:0] sz;

                p = w_prev[k];
                q = p;
                num = '0; mag = '0; m = '0; rq_prod = '0; sp_prod = '0;
                rem5 = '0; frac = '0; t = '0; cksq = '0; rem2 = '0;
                rs_prod = '0; azs = '0; fz = '0; x = '0; y = '0; z = '0;
                at = '0; ck_s = '0; sx = '0; sy = '0; sz = '0;

                if (k == ST_LOAD) begin
                    num = $signed({1'b0, p.idx, 1'b0}) - $signed({2'b00, p.nm1});
                    mag = (num < 0) ? 6'(-num) : 6'(num);
                    q.ck_neg = (num < 0);
                    q.ck_rem = {1'b0, mag};
                    q.ck_mag = '0;
                    m = 19'(p.cnt) * 19'(p.idx) * 19'(6'(p.nm1 - p.idx));
                    q.sq_q.rad  = {3'b000, m, 40'd0};
                    q.sq_q.rem  = '0;
                    q.sq_q.root = '0;
                    rq_prod = 63'(p.radius) * 63'(RECIP5);
                    q.rad_q = rq_prod[62:34];
                    sp_prod = 38'(STEP_C) * 38'(p.nm1);
                    q.dv_rem = 32'(sp_prod[37:12]);
                    q.dv_lo  = {sp_prod[11:0], 20'd0};
                    q.dv_quo = '0;
                end

                if (k == ST_DIV0) begin
                    // Radius times 4/5: four times the fifth, plus the fraction
                    // of the remainder.
                    rem5 = 3'(32'(p.radius) - (32'(p.rad_q) * 32'd5));
                    case (rem5)
                        3'd2:    frac = 2'd1;
                        3'd3:    frac = 2'd2;
                        3'd4:    frac = 2'd3;
                        default: frac = 2'd0;
                    endcase
                    q.r = {p.rad_q, 2'b00} + 31'(frac);
                end

                // Polar cosine magnitude, one quotient bit per stage.
                if (k >= ST_DIV0 && k <= ST_DIV0 + 30) begin
                    t = (k == ST_DIV0) ? p.ck_rem : {p.ck_rem[5:0], 1'b0};
                    if (t >= {1'b0, p.nm1}) begin
                        q.ck_rem = t - {1'b0, p.nm1};
                        q.ck_mag = {p.ck_mag[29:0], 1'b1};
                    end else begin
                        q.ck_rem = t;
                        q.ck_mag = {p.ck_mag[29:0], 1'b0};
                    end
                    q.sq_q = sqrt_step(p.sq_q);
                end

                if (k == ST_SQ) begin
                    cksq = 62'(p.ck_mag) * 62'(p.ck_mag);
                    q.sq_s.rad  = (62'd1 << 60) - cksq;
                    q.sq_s.rem  = '0;
                    q.sq_s.root = '0;
                    q.dv_div = {p.sq_q.root, 1'b0};
                end

                if (k >= ST_SQS0 && k <= ST_SQS0 + 30) begin
                    q.sq_s = sqrt_step(p.sq_s);
                end

                // Azimuth step quotient, one bit per stage.
                if (k >= ST_SQS0 && k <= ST_SQS0 + 31) begin
                    rem2 = {p.dv_rem[30:0], p.dv_lo[31]};
                    q.dv_lo = {p.dv_lo[30:0], 1'b0};
                    if (rem2 >= p.dv_div) begin
                        q.dv_rem = rem2 - p.dv_div;
                        q.dv_quo = {p.dv_quo[30:0], 1'b1};
                    end else begin
                        q.dv_rem = rem2;
                        q.dv_quo = {p.dv_quo[30:0], 1'b0};
                    end
                end

                if (k == ST_RS) begin
                    rs_prod = 62'(p.r) * 62'(p.sq_s.root);
                    q.rs = rs_prod[61:30];
                end

                if (k == ST_AZ) begin
                    azs = 33'(r_az_acc) + 33'(p.dv_quo);
                    if (azs >= 33'(TWO_PI_Q29)) begin
                        azs = azs - 33'(TWO_PI_Q29);
                    end
                    q.az = (p.first || p.last) ? 32'd0 : azs[31:0];
                end

                if (k == ST_FOLD) begin
                    fz = $signed({2'b00, p.az});
                    if (p.az > PI_Q29) begin
                        fz = fz - $signed(34'(TWO_PI_Q29));
                    end
                    q.flip = 1'b0;
                    if (fz > $signed(34'(HALF_PI_Q29))) begin
                        fz = fz - $signed(34'(PI_Q29));
                        q.flip = 1'b1;
                    end else if (fz < -$signed(34'(HALF_PI_Q29))) begin
                        fz = fz + $signed(34'(PI_Q29));
                        q.flip = 1'b1;
                    end
                    q.cor_z = fz <<< 1;
                    q.cor_x = 34'(CORDIC_GAIN);
                    q.cor_y = '0;
                end

                if (k >= ST_COR0 && k < ST_COR0 + CORDIC_STEPS) begin
                    x  = $signed(p.cor_x);
                    y  = $signed(p.cor_y);
                    z  = $signed(p.cor_z);
                    at = $signed(34'(atan_q30(5'(k - ST_COR0))));
                    if (z >= 0) begin
                        q.cor_x = x - (y >>> (k - ST_COR0));
                        q.cor_y = y + (x >>> (k - ST_COR0));
                        q.cor_z = z - at;
                    end else begin
                        q.cor_x = x + (y >>> (k - ST_COR0));
                        q.cor_y = y - (x >>> (k - ST_COR0));
                        q.cor_z = z + at;
                    end
                end

                if (k == ST_MUL) begin
                    x = p.flip ? -$signed(p.cor_x) : $signed(p.cor_x);
                    y = p.flip ? -$signed(p.cor_y) : $signed(p.cor_y);
                    ck_s = p.ck_neg ? -$signed({1'b0, p.ck_mag}) : $signed({1'b0, p.ck_mag});
                    q.px_p = 67'($signed({1'b0, p.rs})) * 67'(x);
                    q.py_p = 67'($signed({1'b0, p.rs})) * 67'(y);
                    q.pz_p = 64'($signed({1'b0, p.r})) * 64'(ck_s);
                end

                if (k == DEPTH) begin
                    if (DIMENSIONS == 2) begin
                        sx = 40'($signed(p.cx)) + 40'($signed({1'b0, p.rs}));
                        sy = 40'($signed(p.cy)) + 40'($signed(p.pz_p) >>> 30);
                        q.mz = '0;
                    end else begin
                        sx = 40'($signed(p.cx)) + 40'($signed(p.px_p) >>> 30);
                        sy = 40'($signed(p.cy)) + 40'($signed(p.py_p) >>> 30);
                        sz = 40'($signed(p.cz)) + 40'($signed(p.pz_p) >>> 30);
                        q.mz = sat32(sz);
                    end
                    q.mx = sat32(sx);
                    q.my = sat32(sy);
                end

                n_pipe[k] = q;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pipe[k].valid <= 1'b0;
                end else if (i_adv) begin
                    r_pipe[k] <= n_pipe[k];
                end
            end
        end
    endgenerate

    // Markers pass the azimuth stage in spiral order, so one running sum serves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az_acc <= '0;
        end else if (i_adv && w_prev[ST_AZ].valid) begin
            r_az_acc <= n_pipe[ST_AZ].az;
        end
    end

    assign o_tail = r_pipe[DEPTH];

endmodule

`default_nettype wire

/* rtl/sphere_surface_spiral_points_top.sv */
// Top level of the spiral marker generator: blob sequencer, count register, marker pipeline.
// Throughput: one marker per cycle unless the output stalls, as the sequencer issues one
// marker per cycle into the 99-stage datapath; a blob yields n_markers (2 to MAX_MARKERS).
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset is synchronous and active low: it empties the pipeline and sets n_markers to 32.
`default_nettype none

module sphere_surface_spiral_points_top
    import ssp_pkg::*;
#(
    parameter int MAX_MARKERS = 64,
    parameter int DIMENSIONS  = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [6:0]  i_cfg_wr_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_center_x,
    input  wire  [31:0] i_center_y,
    input  wire  [31:0] i_center_z,
    input  wire  [30:0] i_blob_radius,
    input  wire  [30:0] i_blob_id,
    input  wire  [15:0] i_blob_cpu,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_marker_x,
    output logic [31:0] o_marker_y,
    output logic [31:0] o_marker_z,
    output logic [30:0] o_owner_id,
    output logic [15:0] o_owner_cpu,
    output logic [5:0]  o_marker_index,
    output logic        o_last
);

    logic [CNT_W-1:0] r_cfg_n;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_nm1;
    logic [31:0]      r_cx;
    logic [31:0]      r_cy;
    logic [31:0]      r_cz;
    logic [30:0]      r_radius;
    logic [30:0]      r_id;
    logic [15:0]      r_cpu;

    logic [CNT_W-1:0] w_cnt;
    logic             w_adv;
    logic             w_issue_last;
    logic             w_accept;
    t_stage           w_issue;
    t_stage           w_tail;

    // The whole pipeline moves whenever its last stage is empty or being taken.
    assign w_adv        = !w_tail.valid || !i_stall;
    assign w_issue_last = r_busy && (r_idx == r_nm1);

    // A new blob is taken once the current one has issued its final marker.
    assign o_stall  = r_busy && !(w_adv && w_issue_last);
    assign w_accept = i_valid && !o_stall;

    // Counts below two act as two, counts above the build limit act as the limit.
    always_comb begin
        if (r_cfg_n < 7'd2) begin
            w_cnt = 7'd2;
        end else if (r_cfg_n > 7'(MAX_MARKERS)) begin
            w_cnt = 7'(MAX_MARKERS);
        end else begin
            w_cnt = r_cfg_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n <= 7'd32;
        end else if (i_cfg_wr_en) begin
            r_cfg_n <= i_cfg_wr_data;
        end
    end

    // Blob sequencer: holds the blob and walks the marker index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && w_adv) begin
            if (w_issue_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= 6'(r_idx + 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cnt    <= w_cnt;
            r_nm1    <= 6'(w_cnt - 7'd1);
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_cz     <= i_center_z;
            r_radius <= i_blob_radius;
            r_id     <= i_blob_id;
            r_cpu    <= i_blob_cpu;
        end
    end

    always_comb begin
        w_issue        = '0;
        w_issue.valid  = r_busy;
        w_issue.cnt    = r_cnt;
        w_issue.nm1    = r_nm1;
        w_issue.idx    = r_idx;
        w_issue.first  = (r_idx == '0);
        w_issue.last   = (r_idx == r_nm1);
        w_issue.cx     = r_cx;
        w_issue.cy     = r_cy;
        w_issue.cz     = r_cz;
        w_issue.radius = r_radius;
        w_issue.id     = r_id;
        w_issue.cpu    = r_cpu;
    end

    ssp_marker_pipe #(
        .DIMENSIONS (DIMENSIONS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_issue (w_issue),
        .o_tail  (w_tail)
    );

    // The last pipeline stage doubles as the output register.
    assign o_valid        = w_tail.valid;
    assign o_marker_x     = w_tail.mx;
    assign o_marker_y     = w_tail.my;
    assign o_marker_z     = w_tail.mz;
    assign o_owner_id     = w_tail.id;
    assign o_owner_cpu    = w_tail.cpu;
    assign o_marker_index = w_tail.idx;
    assign o_last         = w_tail.last;

endmodule

`default_nettype wire
